// ----- rtl/pref_pkg.sv -----
// Package for the peak / rms envelope follower.
// Holds fixed widths, register indexes, the control state type and the root unit status.
// No dependencies.
`timescale 1ns / 1ps

package pref_pkg;

   localparam int SAMPLE_W = 24;
   localparam int LEVEL_W  = 24;
   localparam int DECAY_W  = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int ROOT_STEPS = 12;   // two root bits per step
   localparam int ROOT_CNT_W = 4;

   localparam logic [LEVEL_W-1:0] ENV_FLOOR = 24'd8389;
   localparam logic [LEVEL_W-1:0] UNITY_Q23 = 24'd8388608;

   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_DECAY      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RMS_DECAY       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_CHANNELS = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MERGE,
      ST_PEAK,
      ST_SQUARE,
      ST_ROOT,
      ST_FINISH
   } pref_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } pref_root_status_type;

endpackage

// ----- rtl/pref_if.sv -----
// Request and response channel interfaces for the envelope follower.
// Depends on pref_pkg for field widths.
`timescale 1ns / 1ps

interface pref_req_if
   import pref_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_ch0;
   logic signed [SAMPLE_W-1:0] sample_ch1;
   logic                       block_end;

   modport source (output valid, output sample_ch0, output sample_ch1, output block_end,
                   input ready);
   modport sink   (input valid, input sample_ch0, input sample_ch1, input block_end,
                   output ready);
endinterface

interface pref_rsp_if
   import pref_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] peak_level;
   logic [LEVEL_W-1:0] rms_level;
   logic               block_done;

   modport source (output valid, output peak_level, output rms_level, output block_done,
                   input ready);
   modport sink   (input valid, input peak_level, input rms_level, input block_done,
                   output ready);
endinterface

// ----- rtl/pref_lane.sv -----
// One channel lane: registers the magnitude of a signed Q1.23 sample.
// Depends on pref_pkg.
`timescale 1ns / 1ps

module pref_lane
   import pref_pkg::*;
(
   input  logic                       clock,
   input  logic                       load,
   input  logic signed [SAMPLE_W-1:0] sample,
   output logic        [LEVEL_W-1:0]  abs_level
);

   logic [LEVEL_W-1:0] abs_ff;
   logic [LEVEL_W-1:0] abs_in;

   // full-scale negative maps to exactly 1.0
   always_comb begin
      if (sample[SAMPLE_W-1]) begin
         abs_in = LEVEL_W'(~sample) + LEVEL_W'(1);
      end else begin
         abs_in = LEVEL_W'(sample);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         abs_ff <= abs_in;
      end
   end

   assign abs_level = abs_ff;

endmodule

// ----- rtl/pref_merge.sv -----
// Merge stage: averages the lane magnitudes over the active channels.
// Depends on pref_pkg; fed by pref_lane instances.
`timescale 1ns / 1ps

module pref_merge
   import pref_pkg::*;
#(
   parameter int LANES = 2
) (
   input  logic                 clock,
   input  logic                 load,
   input  logic [1:0]           count,
   input  logic [LEVEL_W-1:0]   lane_level [LANES],
   output logic [LEVEL_W-1:0]   mean_level
);

   logic [LEVEL_W-1:0] mean_ff;
   logic [LEVEL_W-1:0] mean_in;
   logic [LEVEL_W:0]   sum;

   always_comb begin
      sum = '0;
      for (int i = 0; i < LANES; i++) begin
         if (2'(i) < count) begin
            sum = sum + {1'b0, lane_level[i]};
         end
      end
      if (count >= 2'd2) begin
         mean_in = sum[LEVEL_W:1];
      end else begin
         mean_in = sum[LEVEL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mean_ff <= mean_in;
      end
   end

   assign mean_level = mean_ff;

endmodule

// ----- rtl/pref_sqrt.sv -----
// Iterative integer square root of (operand << 23), two root bits per cycle.
// Depends on pref_pkg.
`timescale 1ns / 1ps

module pref_sqrt
   import pref_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [LEVEL_W-1:0]   operand,
   output logic [LEVEL_W-1:0]   root,
   output pref_root_status_type status
);

   localparam int RAD_W = 2 * LEVEL_W;
   localparam int REM_W = LEVEL_W + 3;

   logic [RAD_W-1:0]      rad_ff,  rad_in;
   logic [REM_W-1:0]      rem_ff,  rem_in;
   logic [LEVEL_W-1:0]    root_ff, root_in;
   logic [ROOT_CNT_W-1:0] cnt_ff,  cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   always_comb begin
      logic [REM_W-1:0]   r;
      logic [REM_W-1:0]   shifted;
      logic [REM_W-1:0]   trial;
      logic [LEVEL_W-1:0] q;
      logic [RAD_W-1:0]   v;
      r = rem_ff;
      q = root_ff;
      v = rad_ff;
      for (int k = 0; k < 2; k++) begin
         shifted = {r[REM_W-3:0], v[RAD_W-1 -: 2]};
         trial   = {1'b0, q, 2'b01};
         v       = {v[RAD_W-3:0], 2'b00};
         if (shifted >= trial) begin
            r = shifted - trial;
            q = {q[LEVEL_W-2:0], 1'b1};
         end else begin
            r = shifted;
            q = {q[LEVEL_W-2:0], 1'b0};
         end
      end
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = {1'b0, operand, 23'd0};
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = v;
         rem_in  = r;
         root_in = q;
         cnt_in  = cnt_ff + ROOT_CNT_W'(1);
         if (cnt_ff == ROOT_CNT_W'(ROOT_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root        = root_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ----- rtl/peak_rms_envelope_follower.sv -----
// Top level of the peak / rms envelope follower: lanes, merge, envelope update, root unit.
// Depends on pref_pkg, pref_if, pref_lane, pref_merge, pref_sqrt.
//
//   channel  | direction | beat contents
//   req_bus  | in        | sample_ch0, sample_ch1, block_end
//   rsp_bus  | out       | peak_level, rms_level, block_done
//   csr_*    | in        | csr_we, csr_index, csr_data (write only)
//
// A frame goes from accept through the merge, peak, square, root and finish states to a response beat.
// The next frame is accepted once the response is in the output register.
// Reset is synchronous: envelopes clear, decays go to 65535, two channels.
// A stalled response holds its register; the core waits until it is taken.
`timescale 1ns / 1ps

module peak_rms_envelope_follower
   import pref_pkg::*;
#(
   parameter int CHANNELS = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   pref_req_if.sink              req_bus,
   pref_rsp_if.source            rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int LANES = (CHANNELS < 2) ? 1 : 2;
   localparam logic [1:0] LIMIT = 2'(LANES);

   pref_state_type state_ff, state_in;

   logic [DECAY_W-1:0] peak_decay_ff;
   logic [DECAY_W-1:0] rms_decay_ff;
   logic [1:0]         active_ff;

   logic [LEVEL_W-1:0] peak_ff, peak_in;
   logic [LEVEL_W-1:0] sqenv_ff, sqenv_in;
   logic [LEVEL_W-1:0] sq_ff, sq_in;
   logic               blk_ff;

   logic               rsp_valid_ff;
   logic [LEVEL_W-1:0] rsp_peak_ff;
   logic [LEVEL_W-1:0] rsp_rms_ff;
   logic               rsp_blk_ff;

   logic req_fire, rsp_free;
   logic lane_load, mean_load, peak_we, sqenv_we, root_start, rsp_load;
   logic [1:0] n_active;

   logic signed [SAMPLE_W-1:0] lane_sample [LANES];
   logic        [LEVEL_W-1:0]  lane_level  [LANES];
   logic        [LEVEL_W-1:0]  mean_level;
   logic        [LEVEL_W-1:0]  root_level;
   pref_root_status_type       root_status;

   logic [LEVEL_W+DECAY_W-1:0] peak_rel_prod;
   logic [LEVEL_W+DECAY_W-1:0] sq_rel_prod;
   logic [LEVEL_W+DECAY_W-1:0] sq_att_prod;
   logic [2*LEVEL_W-1:0]       mean_sq_prod;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;
   assign n_active = (active_ff > LIMIT) ? LIMIT : active_ff;

   // lanes
   assign lane_sample[0] = req_bus.sample_ch0;
   if (LANES > 1) begin : g_ch1
      assign lane_sample[1] = req_bus.sample_ch1;
   end

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      pref_lane u_lane (
         .clock     (clock),
         .load      (lane_load),
         .sample    (lane_sample[i]),
         .abs_level (lane_level[i])
      );
   end

   pref_merge #(.LANES(LANES)) u_merge (
      .clock      (clock),
      .load       (mean_load),
      .count      (n_active),
      .lane_level (lane_level),
      .mean_level (mean_level)
   );

   // control
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_fire) state_in = ST_MERGE;
         ST_MERGE:  state_in = ST_PEAK;
         ST_PEAK:   state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_ROOT;
         ST_ROOT:   if (root_status.done) state_in = ST_FINISH;
         ST_FINISH: if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_bus.ready = 1'b0;
      mean_load     = 1'b0;
      peak_we       = 1'b0;
      sqenv_we      = 1'b0;
      root_start    = 1'b0;
      rsp_load      = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_bus.ready = 1'b1;
         ST_MERGE:  mean_load     = 1'b1;
         ST_PEAK:   peak_we       = 1'b1;
         ST_SQUARE: begin
            sqenv_we   = 1'b1;
            root_start = 1'b1;
         end
         ST_ROOT:   ;
         ST_FINISH: rsp_load = rsp_free;
         default:   ;
      endcase
   end

   assign lane_load = req_fire;

   // envelope update
   assign peak_rel_prod = peak_ff * peak_decay_ff;
   assign mean_sq_prod  = mean_level * mean_level;
   assign sq_rel_prod   = sqenv_ff * peak_decay_ff;
   assign sq_att_prod   = sq_ff * rms_decay_ff;

   always_comb begin
      peak_in = peak_ff;
      sq_in   = mean_sq_prod[LEVEL_W+22:23];
      if (n_active != 2'd0) begin
         if (mean_level > peak_ff) begin
            peak_in = mean_level;
         end else if (peak_ff >= ENV_FLOOR) begin
            peak_in = peak_rel_prod[LEVEL_W+DECAY_W-1:DECAY_W];
         end else begin
            peak_in = '0;
         end
      end
   end

   always_comb begin
      sqenv_in = sqenv_ff;
      if (n_active != 2'd0) begin
         if (sq_ff > sqenv_ff) begin
            sqenv_in = sq_att_prod[LEVEL_W+DECAY_W-1:DECAY_W];
         end else if (sqenv_ff >= ENV_FLOOR) begin
            sqenv_in = sq_rel_prod[LEVEL_W+DECAY_W-1:DECAY_W];
         end else begin
            sqenv_in = '0;
         end
      end
   end

   pref_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (root_start),
      .operand (sqenv_in),
      .root    (root_level),
      .status  (root_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         peak_decay_ff <= 16'hFFFF;
         rms_decay_ff  <= 16'hFFFF;
         active_ff     <= 2'd2;
         peak_ff       <= '0;
         sqenv_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_PEAK_DECAY:      peak_decay_ff <= csr_data;
               CSR_RMS_DECAY:       rms_decay_ff  <= csr_data;
               CSR_ACTIVE_CHANNELS: active_ff     <= csr_data[1:0];
               default:             ;
            endcase
         end
         if (peak_we) begin
            peak_ff <= peak_in;
         end
         if (sqenv_we) begin
            sqenv_ff <= sqenv_in;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_fire) begin
         blk_ff <= req_bus.block_end;
      end
      if (peak_we) begin
         sq_ff <= sq_in;
      end
      if (rsp_load) begin
         rsp_peak_ff <= peak_ff;
         rsp_rms_ff  <= root_level;
         rsp_blk_ff  <= blk_ff;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.peak_level = rsp_peak_ff;
   assign rsp_bus.rms_level  = rsp_rms_ff;
   assign rsp_bus.block_done = rsp_blk_ff;

`ifndef SYNTH
   a_idle_root_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !root_status.busy)
      else $error("root unit busy while core idle");

   a_done_in_root: assert property (@(posedge clock) disable iff (reset)
      root_status.done |-> state_ff == ST_ROOT)
      else $error("root done outside root wait");

   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH && rsp_valid_ff && !rsp_bus.ready |=> state_ff == ST_FINISH)
      else $error("finished frame dropped while response stalled");

   a_env_range: assert property (@(posedge clock) disable iff (reset)
      peak_ff <= UNITY_Q23 && sqenv_ff <= UNITY_Q23)
      else $error("envelope above unity");
`endif

endmodule

// ----- tb/pref_level_check.sv -----
// Envelope level checker: watches the request, response and register ports of the follower,
// predicts peak and rms levels per frame and compares every response beat.
// Depends on pref_pkg and pref_if.
`timescale 1ns / 1ps

module pref_level_check
   import pref_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   pref_req_if                   req_bus,
   pref_rsp_if                   rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    fail_count,
   output int                    outstanding
);

   localparam logic [1:0] MAX_LANES = 2'd2;

   typedef struct packed {
      logic [LEVEL_W-1:0] peak_level;
      logic [LEVEL_W-1:0] rms_level;
      logic               block_done;
   } level_beat_type;

   logic [DECAY_W-1:0] peak_coef;
   logic [DECAY_W-1:0] square_coef;
   logic [1:0]         lane_sel;
   logic [LEVEL_W-1:0] peak_env;
   logic [LEVEL_W-1:0] square_env;
   level_beat_type     pending_levels[$];
   int                 fail_total = 0;

   assign fail_count = fail_total;

   task automatic report(input string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      fail_total++;
   endtask

   function automatic logic [SAMPLE_W:0] magnitude(input logic signed [SAMPLE_W-1:0] s);
      logic signed [SAMPLE_W:0] wide;
      wide = {s[SAMPLE_W-1], s};
      if (wide < 0)
         wide = -wide;
      return unsigned'(wide);
   endfunction

   function automatic logic [LEVEL_W-1:0] scale(input logic [LEVEL_W-1:0] v,
                                                input logic [DECAY_W-1:0] coef);
      logic [LEVEL_W+DECAY_W-1:0] prod;
      prod = {{DECAY_W{1'b0}}, v} * {{LEVEL_W{1'b0}}, coef};
      return prod[LEVEL_W+DECAY_W-1:DECAY_W];
   endfunction

   // release toward zero, snapping to zero under the floor
   function automatic logic [LEVEL_W-1:0] released(input logic [LEVEL_W-1:0] env);
      if (env < ENV_FLOOR)
         return '0;
      return scale(env, peak_coef);
   endfunction

   // bitwise root of env in Q1.23: largest r with r*r <= env << 23
   function automatic logic [LEVEL_W-1:0] root_level(input logic [LEVEL_W-1:0] env);
      logic [2*LEVEL_W-1:0] target;
      logic [LEVEL_W-1:0]   acc;
      logic [LEVEL_W-1:0]   trial;
      target = {1'b0, env, 23'b0};
      acc = '0;
      for (int i = LEVEL_W - 1; i >= 0; i--) begin
         trial = acc;
         trial[i] = 1'b1;
         if ({{LEVEL_W{1'b0}}, trial} * {{LEVEL_W{1'b0}}, trial} <= target)
            acc = trial;
      end
      return acc;
   endfunction

   function automatic level_beat_type predict_frame(input logic signed [SAMPLE_W-1:0] ch0,
                                                    input logic signed [SAMPLE_W-1:0] ch1,
                                                    input logic last);
      logic [1:0]             lanes;
      logic [SAMPLE_W:0]      mean;
      logic [2*SAMPLE_W-1:0]  power;
      logic [LEVEL_W-1:0]     square;
      level_beat_type         beat;
      lanes = (lane_sel > MAX_LANES) ? MAX_LANES : lane_sel;
      if (lanes != 2'd0) begin
         if (lanes == 2'd1)
            mean = magnitude(ch0);
         else
            mean = (magnitude(ch0) + magnitude(ch1)) >> 1;
         if (mean > {1'b0, peak_env})
            peak_env = mean[LEVEL_W-1:0];
         else
            peak_env = released(peak_env);
         power = {{(SAMPLE_W-1){1'b0}}, mean} * {{(SAMPLE_W-1){1'b0}}, mean};
         square = power[LEVEL_W+22:23];
         if (square > square_env)
            square_env = scale(square, square_coef);
         else
            square_env = released(square_env);
      end
      beat.peak_level = peak_env;
      beat.rms_level  = root_level(square_env);
      beat.block_done = last;
      return beat;
   endfunction

   always @(posedge clock) begin
      level_beat_type want;
      if (reset) begin
         peak_coef   = '1;
         square_coef = '1;
         lane_sel    = 2'd2;
         peak_env    = '0;
         square_env  = '0;
         pending_levels.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PEAK_DECAY:      peak_coef   = csr_data[DECAY_W-1:0];
               CSR_RMS_DECAY:       square_coef = csr_data[DECAY_W-1:0];
               CSR_ACTIVE_CHANNELS: lane_sel    = csr_data[1:0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready)
            pending_levels.push_back(predict_frame(req_bus.sample_ch0, req_bus.sample_ch1,
                                                   req_bus.block_end));
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_levels.size() == 0) begin
               report("response beat with no frame pending");
            end else begin
               want = pending_levels.pop_front();
               if (rsp_bus.peak_level !== want.peak_level)
                  report($sformatf("peak_level got %0d want %0d",
                                   rsp_bus.peak_level, want.peak_level));
               if (rsp_bus.rms_level !== want.rms_level)
                  report($sformatf("rms_level got %0d want %0d",
                                   rsp_bus.rms_level, want.rms_level));
               if (rsp_bus.block_done !== want.block_done)
                  report($sformatf("block_done got %b want %b",
                                   rsp_bus.block_done, want.block_done));
            end
         end
      end
      outstanding <= pending_levels.size();
   end

endmodule

// ----- tb/tb_peak_rms_envelope_follower.sv -----
// Testbench top for the peak / rms envelope follower: clock, reset, register writes,
// frame and response traffic with random idling; the verdict comes from pref_level_check.
// Depends on pref_pkg, pref_if, peak_rms_envelope_follower and pref_level_check.
`timescale 1ns / 1ps

module tb_peak_rms_envelope_follower;
   import pref_pkg::*;

   localparam logic signed [SAMPLE_W-1:0] MOST_NEG = 24'sh800000;
   localparam logic signed [SAMPLE_W-1:0] MOST_POS = 24'sh7FFFFF;
   localparam int PHASE_FRAMES = 155;
   localparam int SETTLE_CYCLES = 20;

   typedef enum int {QUIET, MIXED, LOUD} frame_mood_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   int                    fail_count;
   int                    outstanding;
   int                    send_idle_max = 13;
   int                    rsp_idle_max = 13;
   int                    hold_cycles = 0;

   pref_req_if req_bus ();
   pref_rsp_if rsp_bus ();

   peak_rms_envelope_follower dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   pref_level_check level_check (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always #5 clock = ~clock;

   // valid stays up across back-to-back frames; lowered here only for a gap (wait_quiet also lowers it)
   task automatic send_frame(input logic signed [SAMPLE_W-1:0] ch0,
                             input logic signed [SAMPLE_W-1:0] ch1,
                             input logic last);
      int gap;
      gap = $urandom_range(0, send_idle_max);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.sample_ch0 <= ch0;
      req_bus.sample_ch1 <= ch1;
      req_bus.block_end  <= last;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic wait_quiet();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_follower(input logic [DECAY_W-1:0] peak_coef,
                               input logic [DECAY_W-1:0] rms_coef,
                               input logic [1:0] lanes);
      csr_we    <= 1'b1;
      csr_index <= CSR_PEAK_DECAY;
      csr_data  <= CSR_DATA_W'(peak_coef);
      @(posedge clock);
      csr_index <= CSR_RMS_DECAY;
      csr_data  <= CSR_DATA_W'(rms_coef);
      @(posedge clock);
      csr_index <= CSR_ACTIVE_CHANNELS;
      csr_data  <= CSR_DATA_W'(lanes);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [DECAY_W-1:0] draw_coef();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         return '0;
      if (pick == 1)
         return '1;
      if (pick < 4)
         return DECAY_W'($urandom);
      return DECAY_W'($urandom_range(30000, 64000));
   endfunction

   function automatic logic [1:0] draw_lanes();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         return 2'd0;
      if (pick == 1)
         return 2'd3;
      if (pick < 5)
         return 2'd1;
      return 2'd2;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] draw_sample(input frame_mood_type mood);
      logic [SAMPLE_W-1:0] mag;
      int pick;
      pick = $urandom_range(0, 3);
      case (mood)
         QUIET: mag = (pick == 0) ? '0 : SAMPLE_W'($urandom_range(0, 64));
         LOUD: begin
            if (pick == 0)
               mag = MOST_NEG;
            else if (pick == 1)
               mag = MOST_POS;
            else
               mag = SAMPLE_W'($urandom_range(4194304, 8388607));
         end
         default: begin
            mag = SAMPLE_W'($urandom);
            if (pick >= 2)
               mag = mag & ((24'd1 << $urandom_range(1, 23)) - 24'd1);
         end
      endcase
      if ($urandom_range(0, 1) == 1)
         mag = -mag;
      return signed'(mag);
   endfunction

   // response side: random stall per beat, or one long hold when asked
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (hold_cycles > 0) begin
            stall = hold_cycles;
            hold_cycles = 0;
         end else begin
            stall = $urandom_range(0, rsp_idle_max);
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   initial begin
      #(4_000_000);
      $display("peak_rms_envelope_follower verification failed");
      $finish;
   end

   initial begin
      int             sent;
      int             seg_len;
      frame_mood_type mood;
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= '0;
      csr_data           <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.sample_ch0 <= '0;
      req_bus.sample_ch1 <= '0;
      req_bus.block_end  <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings: two lanes, both coefficients at full scale
      send_frame('0, '0, 1'b0);
      send_frame(MOST_POS, MOST_POS, 1'b1);
      send_frame(MOST_NEG, MOST_NEG, 1'b0);
      send_frame(MOST_NEG, MOST_NEG, 1'b1);
      send_frame(MOST_POS, MOST_NEG, 1'b0);
      send_frame(24'sd1, -24'sd1, 1'b0);
      send_frame('0, '0, 1'b1);
      wait_quiet();

      // zero coefficients, one lane, second lane ignored
      set_follower('0, '0, 2'd1);
      send_frame(MOST_NEG, 24'sd5, 1'b0);
      send_frame('0, MOST_POS, 1'b1);
      send_frame('0, MOST_NEG, 1'b0);
      wait_quiet();

      // walk the peak across the floor
      set_follower('1, '1, 2'd1);
      send_frame(24'sd8389, draw_sample(MIXED), 1'b0);
      send_frame('0, draw_sample(MIXED), 1'b0);
      send_frame('0, draw_sample(MIXED), 1'b1);
      send_frame(-24'sd8389, '0, 1'b0);
      wait_quiet();

      // no lanes: envelopes hold
      set_follower(16'd12345, 16'd54321, 2'd0);
      send_frame(MOST_POS, MOST_NEG, 1'b1);
      send_frame(-24'sd100, 24'sd77, 1'b0);
      wait_quiet();

      // lane count above the limit saturates
      set_follower(16'd40000, '1, 2'd3);
      send_frame(MOST_NEG, MOST_POS, 1'b1);
      send_frame(24'sd4000000, -24'sd4000000, 1'b0);
      send_frame('0, '0, 1'b0);
      wait_quiet();

      // random phases: bursts of loud, quiet and mixed frames
      for (int ph = 0; ph < 6; ph++) begin
         send_idle_max = (ph % 3 == 1) ? 0 : 13;
         rsp_idle_max  = (ph % 3 == 2) ? 0 : 13;
         set_follower(draw_coef(), draw_coef(), draw_lanes());
         if (ph == 1)
            hold_cycles = 400;
         sent = 0;
         while (sent < PHASE_FRAMES) begin
            mood = frame_mood_type'($urandom_range(0, 2));
            seg_len = $urandom_range(1, 24);
            for (int k = 0; k < seg_len && sent < PHASE_FRAMES; k++) begin
               send_frame(draw_sample(mood), draw_sample(mood), 1'($urandom_range(0, 1)));
               sent++;
            end
         end
         wait_quiet();
      end

      if (fail_count == 0)
         $display("peak_rms_envelope_follower verification clean");
      else
         $display("peak_rms_envelope_follower verification failed");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/pref_pkg.sv
rtl/pref_if.sv
rtl/pref_lane.sv
rtl/pref_merge.sv
rtl/pref_sqrt.sv
rtl/peak_rms_envelope_follower.sv
tb/pref_level_check.sv
tb/tb_peak_rms_envelope_follower.sv
